### rtl/sitda_pkg.sv
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared types, constants and the shift-and-add-3 step for the signed integer
// to decimal text converter.
// ----------------------------------------------------------------------------
package sitda_pkg;

   localparam int unsigned NUMBER_WIDTH   = 32;
   localparam int unsigned CHAR_WIDTH     = 6;
   localparam int unsigned NUM_DIGITS     = 10;
   localparam int unsigned BCD_WIDTH      = 4 * NUM_DIGITS;
   localparam int unsigned BITS_PER_STAGE = 8;
   localparam int unsigned NUM_STAGES     = NUMBER_WIDTH / BITS_PER_STAGE;
   localparam int unsigned IDX_WIDTH      = 4;

   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 6'd45;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 6'd48;

   typedef logic [BCD_WIDTH+NUMBER_WIDTH-1:0] dabble_reg_type;

   // One word moving through the conversion pipe.
   typedef struct packed {
      logic                    neg;
      dabble_reg_type          dabble;  // {bcd, remaining binary}
   } conv_word_type;

   // One double-dabble step: correct every BCD digit that is 5 or more, then
   // shift the whole register left by one.
   function automatic dabble_reg_type dabble_step(input dabble_reg_type s);
      dabble_reg_type t;
      logic [3:0]     dig;
      t = s;
      for (int d = 0; d < NUM_DIGITS; d++) begin
         dig = t[NUMBER_WIDTH + 4*d +: 4];
         if (dig >= 4'd5) begin
            t[NUMBER_WIDTH + 4*d +: 4] = dig + 4'd3;
         end
      end
      return {t[BCD_WIDTH+NUMBER_WIDTH-2:0], 1'b0};
   endfunction

endpackage

### rtl/sitda_mag.sv
// ----------------------------------------------------------------------------
// sitda_mag
// First pipe stage: splits the signed input into sign and unsigned magnitude.
// ----------------------------------------------------------------------------
module sitda_mag (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic [sitda_pkg::NUMBER_WIDTH-1:0]  in_number,
   output logic                                out_valid,
   input  logic                                out_ready,
   output sitda_pkg::conv_word_type            out_word
);
   import sitda_pkg::*;

   logic                              valid_ff;
   conv_word_type                     word_ff;
   conv_word_type                     word_in;
   logic [NUMBER_WIDTH-1:0]           mag;

   // Magnitude as unsigned, so the most negative value needs no special case.
   assign mag = in_number[NUMBER_WIDTH-1] ? (NUMBER_WIDTH'(0) - in_number) : in_number;

   always_comb begin
      word_in.neg    = in_number[NUMBER_WIDTH-1];
      word_in.dabble = {{BCD_WIDTH{1'b0}}, mag};
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

endmodule

### rtl/sitda_dabble.sv
// ----------------------------------------------------------------------------
// sitda_dabble
// One double-dabble pipe stage: consumes a fixed slice of magnitude bits.
// ----------------------------------------------------------------------------
module sitda_dabble (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  sitda_pkg::conv_word_type  in_word,
   output logic                      out_valid,
   input  logic                      out_ready,
   output sitda_pkg::conv_word_type  out_word
);
   import sitda_pkg::*;

   logic           valid_ff;
   conv_word_type  word_ff;
   conv_word_type  word_in;

   always_comb begin
      word_in = in_word;
      for (int k = 0; k < BITS_PER_STAGE; k++) begin
         word_in.dabble = dabble_step(word_in.dabble);
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

endmodule

### rtl/sitda_ser.sv
// ----------------------------------------------------------------------------
// sitda_ser
// Character serializer: holds one converted number and sends its sign and
// significant digits, most significant first, one character per word.
// ----------------------------------------------------------------------------
module sitda_ser (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  sitda_pkg::conv_word_type           in_word,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [sitda_pkg::CHAR_WIDTH-1:0]   rsp_text_char,
   output logic                               rsp_is_last
);
   import sitda_pkg::*;

   logic                   busy_ff;
   logic                   busy_in;
   logic                   minus_ff;
   logic                   minus_in;
   logic [IDX_WIDTH-1:0]   idx_ff;
   logic [IDX_WIDTH-1:0]   idx_in;
   logic [BCD_WIDTH-1:0]   bcd_ff;
   logic [BCD_WIDTH-1:0]   new_bcd;
   logic [IDX_WIDTH-1:0]   top_idx;
   logic [3:0]             cur_digit;
   logic                   out_take;
   logic                   load;

   assign new_bcd = in_word.dabble[BCD_WIDTH+NUMBER_WIDTH-1:NUMBER_WIDTH];

   // Highest nonzero digit; zero keeps index 0 so a lone '0' goes out.
   always_comb begin
      top_idx = '0;
      for (int d = 0; d < NUM_DIGITS; d++) begin
         if (new_bcd[4*d +: 4] != 4'd0) begin
            top_idx = IDX_WIDTH'(d);
         end
      end
   end

   assign cur_digit     = bcd_ff[4*idx_ff +: 4];
   assign rsp_valid     = busy_ff;
   assign rsp_text_char = minus_ff ? CHAR_MINUS : (CHAR_ZERO + {2'b00, cur_digit});
   assign rsp_is_last   = !minus_ff && (idx_ff == '0);

   assign out_take = busy_ff && !rsp_stall;
   assign in_ready = !busy_ff || (out_take && rsp_is_last);
   assign load     = in_ready && in_valid;

   always_comb begin
      busy_in  = busy_ff;
      minus_in = minus_ff;
      idx_in   = idx_ff;
      if (load) begin
         busy_in  = 1'b1;
         minus_in = in_word.neg;
         idx_in   = top_idx;
      end else if (out_take) begin
         if (rsp_is_last) begin
            busy_in = 1'b0;
         end else if (minus_ff) begin
            minus_in = 1'b0;
         end else begin
            idx_in = idx_ff - IDX_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         minus_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         minus_ff <= minus_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bcd_ff <= new_bcd;
      end
   end

endmodule

### rtl/signed_int_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// Signed 32-bit integer to decimal ASCII text, most significant digit first.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one signed 32-bit number per word (valid/stall handshake).
//   rsp_* carries one ASCII character per word: an optional '-' and then the
//   significant digits; rsp_is_last marks the final character of a number.
//   Zero gives the single character '0'.
// Path: a number taken passes the sign stage, four 8-bit double-dabble
//   stages and the serializer, each of which registers it.
// Throughput: while rsp_stall is low the serializer sends one character per
//   cycle; a number is 1 to 11 characters, and a waiting next number's first
//   character follows the previous last one with no gap. Up to six numbers
//   are in flight, so input is taken every cycle while the pipe fills.
// Stall: rsp_stall holds the current character; the pipe stages back up one
//   by one and req_stall rises only once every stage holds a word.
// Reset: synchronous, clears all valid bits; nothing is in flight afterwards.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [sitda_pkg::NUMBER_WIDTH-1:0] req_number,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [sitda_pkg::CHAR_WIDTH-1:0]   rsp_text_char,
   output logic                               rsp_is_last
);
   import sitda_pkg::*;

   logic           req_ready;
   logic           stage_valid [0:NUM_STAGES];
   logic           stage_ready [0:NUM_STAGES];
   conv_word_type  stage_word  [0:NUM_STAGES];

   assign req_stall = !req_ready;

   sitda_mag u_mag (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_number (req_number),
      .out_valid (stage_valid[0]),
      .out_ready (stage_ready[0]),
      .out_word  (stage_word[0])
   );

   for (genvar s = 0; s < NUM_STAGES; s++) begin : g_dabble
      sitda_dabble u_dabble (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[s]),
         .in_ready  (stage_ready[s]),
         .in_word   (stage_word[s]),
         .out_valid (stage_valid[s+1]),
         .out_ready (stage_ready[s+1]),
         .out_word  (stage_word[s+1])
      );
   end

   sitda_ser u_ser (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (stage_valid[NUM_STAGES]),
      .in_ready      (stage_ready[NUM_STAGES]),
      .in_word       (stage_word[NUM_STAGES]),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_text_char (rsp_text_char),
      .rsp_is_last   (rsp_is_last)
   );

endmodule

### rtl/sitda_checker.sv
// ----------------------------------------------------------------------------
// sitda_checker
// Port-level checks for the decimal text converter, bound to the top level.
// ----------------------------------------------------------------------------
module sitda_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic [sitda_pkg::CHAR_WIDTH-1:0]   rsp_text_char,
   input  logic                               rsp_is_last
);
   import sitda_pkg::*;

   // High when the next character shown starts a new number.
   logic at_start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         at_start_ff <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
         at_start_ff <= rsp_is_last;
      end
   end

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word shown right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_text_char) && $stable(rsp_is_last)))
      else $error("stalled result word changed");

   // Minus only as first character of a number and never alone.
   a_minus_place: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_text_char == CHAR_MINUS) |-> (at_start_ff && !rsp_is_last))
      else $error("misplaced minus sign");

   // A leading zero digit is only allowed as the whole text of zero.
   a_no_lead_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && at_start_ff && rsp_text_char == CHAR_ZERO) |-> rsp_is_last)
      else $error("leading zero not suppressed");

endmodule

bind signed_int_to_decimal_ascii_unit sitda_checker u_sitda_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_text_char (rsp_text_char),
   .rsp_is_last   (rsp_is_last)
);
